[sv/wsm_pkg.sv]
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared widths, constants and control types of the waveset metrics block.
// ----------------------------------------------------------------------------
package wsm_pkg;

    // running sum of squares, saturating
    localparam int SUM_W = 63;
    localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

    // peak counter, saturating
    localparam int PEAK_W = 16;
    localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

    // square root result width (root of a 63-bit value)
    localparam int ROOT_W = 32;

    // result field widths
    localparam int RMS_W     = 24;
    localparam int LEN_OUT_W = 17;
    localparam int DUR_W     = 21;

    // duration scaling: length * 2^DUR_SHIFT / RATE_HZ
    localparam int DUR_SHIFT = 20;
    localparam int RATE_W    = 16;
    localparam logic [RATE_W-1:0] RATE_HZ = 16'd44100;

    // per-sample duration step: whole units plus a fraction in 1/RATE_HZ
    localparam int FRAC_W = RATE_W + 1;
    localparam logic [DUR_W-1:0]  DUR_WHOLE = DUR_W'((1 << DUR_SHIFT) / int'(RATE_HZ));
    localparam logic [FRAC_W-1:0] DUR_FRAC  = FRAC_W'((1 << DUR_SHIFT) % int'(RATE_HZ));

    // accumulator control from the sequencer
    typedef struct packed {
        logic mul;    // square the held sample, update count and peak history
        logic add;    // add the held square into the running sum
        logic clear;  // start a new waveset
    } wsm_acc_ctrl_t;

    // accumulator status back to the sequencer
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [PEAK_W-1:0] peak;
        logic [DUR_W-1:0]  dur;
        logic              over;
    } wsm_acc_stat_t;

endpackage

[sv/wsm_accum.sv]
// ----------------------------------------------------------------------------
// wsm_accum
// Per-sample accumulation: square, saturating sum, count, duration and
// local maxima.
// ----------------------------------------------------------------------------
module wsm_accum #(
    parameter int MAX_LEN     = 65536,
    parameter int SAMPLE_BITS = 24,
    parameter int CNT_W       = 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsm_pkg::wsm_acc_ctrl_t        ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic [CNT_W-1:0]              count,
    output wsm_pkg::wsm_acc_stat_t        stat
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

    logic [wsm_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [wsm_pkg::SUM_W-1:0]  sq_reg, sq_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [wsm_pkg::PEAK_W-1:0] peak_reg, peak_next;
    logic [wsm_pkg::DUR_W-1:0]  dur_reg, dur_next;
    logic [wsm_pkg::FRAC_W-1:0] frac_reg, frac_next;
    logic                       over_reg, over_next;
    logic signed [SAMPLE_BITS-1:0] prev_one_reg, prev_one_next;
    logic signed [SAMPLE_BITS-1:0] prev_two_reg, prev_two_next;
    logic [1:0]                 hist_reg, hist_next;

    logic [SAMPLE_BITS-1:0]     mag;
    logic [2*SAMPLE_BITS-1:0]   prod;
    logic [wsm_pkg::SUM_W:0]    total;
    logic [wsm_pkg::FRAC_W-1:0] frac_sum;
    logic                       is_peak;

    // magnitude and square of the held sample
    assign mag  = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    assign prod = mag * mag;

    // saturating sum
    assign total = {1'b0, sum_reg} + {1'b0, sq_reg};

    // duration fraction after one more sample
    assign frac_sum = frac_reg + wsm_pkg::DUR_FRAC;

    // strict local maximum at the previous sample
    assign is_peak = (hist_reg == 2'd2) && (prev_one_reg > prev_two_reg)
                     && (sample < prev_one_reg);

    // next state
    always_comb
    begin
        sum_next      = sum_reg;
        sq_next       = sq_reg;
        count_next    = count_reg;
        peak_next     = peak_reg;
        dur_next      = dur_reg;
        frac_next     = frac_reg;
        over_next     = over_reg;
        prev_one_next = prev_one_reg;
        prev_two_next = prev_two_reg;
        hist_next     = hist_reg;
        if (ctrl.clear)
        begin
            sum_next      = '0;
            count_next    = '0;
            peak_next     = '0;
            dur_next      = '0;
            frac_next     = '0;
            over_next     = 1'b0;
            prev_one_next = '0;
            prev_two_next = '0;
            hist_next     = 2'd0;
        end
        else if (ctrl.mul)
        begin
            if (count_reg >= CNT_MAX)
            begin
                // sample past the limit only marks the overflow
                over_next = 1'b1;
                sq_next   = '0;
            end
            else
            begin
                sq_next    = wsm_pkg::SUM_W'(prod);
                count_next = count_reg + 1'b1;
                // duration grows by one sample period, carry on a full unit
                if (frac_sum >= {1'b0, wsm_pkg::RATE_HZ})
                begin
                    frac_next = frac_sum - {1'b0, wsm_pkg::RATE_HZ};
                    dur_next  = dur_reg + wsm_pkg::DUR_WHOLE + 1'b1;
                end
                else
                begin
                    frac_next = frac_sum;
                    dur_next  = dur_reg + wsm_pkg::DUR_WHOLE;
                end
                if (is_peak && (peak_reg != wsm_pkg::PEAK_MAX))
                begin
                    peak_next = peak_reg + 1'b1;
                end
                prev_two_next = prev_one_reg;
                prev_one_next = sample;
                if (hist_reg != 2'd2)
                begin
                    hist_next = hist_reg + 2'd1;
                end
            end
        end
        else if (ctrl.add)
        begin
            if (total > {1'b0, wsm_pkg::SUM_LIMIT})
            begin
                sum_next = wsm_pkg::SUM_LIMIT;
            end
            else
            begin
                sum_next = total[wsm_pkg::SUM_W-1:0];
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            count_reg    <= '0;
            peak_reg     <= '0;
            dur_reg      <= '0;
            frac_reg     <= '0;
            over_reg     <= 1'b0;
            prev_one_reg <= '0;
            prev_two_reg <= '0;
            hist_reg     <= 2'd0;
        end
        else
        begin
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            peak_reg     <= peak_next;
            dur_reg      <= dur_next;
            frac_reg     <= frac_next;
            over_reg     <= over_next;
            prev_one_reg <= prev_one_next;
            prev_two_reg <= prev_two_next;
            hist_reg     <= hist_next;
        end
    end

    // held square, payload only
    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign count     = count_reg;
    assign stat.sum  = sum_reg;
    assign stat.peak = peak_reg;
    assign stat.dur  = dur_reg;
    assign stat.over = over_reg;

    // count never passes the limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("sample count above limit");

    // overflow only once the count is full
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        over_reg |-> (count_reg == CNT_MAX))
        else $error("overflow set with count below limit");

    // duration fraction stays below one unit
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        frac_reg < {1'b0, wsm_pkg::RATE_HZ})
        else $error("duration fraction out of range");

    // clear empties the waveset state
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (count_reg == '0 && peak_reg == '0 && !over_reg && sum_reg == '0))
        else $error("state not cleared");

endmodule

[sv/wsm_divider.sv]
// ----------------------------------------------------------------------------
// wsm_divider
// Restoring divider, one quotient bit per cycle, for the mean square.
// ----------------------------------------------------------------------------
module wsm_divider #(
    parameter int NUM_W = 63,
    parameter int DEN_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] shift_reg, shift_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // trial subtract of the next dividend bit
    assign trial = {rem_reg, shift_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // step control
    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(NUM_W);
            shift_next = num;
            rem_next   = '0;
            den_next   = den;
        end
        else if (busy_reg)
        begin
            cnt_next   = cnt_reg - 1'b1;
            shift_next = {shift_reg[NUM_W-2:0], fits};
            rem_next   = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
    end

    assign busy = busy_reg;
    assign quot = shift_reg;

endmodule

[sv/wsm_isqrt.sv]
// ----------------------------------------------------------------------------
// wsm_isqrt
// Integer square root of the mean square, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module wsm_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wsm_pkg::SUM_W-1:0]   radicand,
    output logic                        busy,
    output logic [wsm_pkg::ROOT_W-1:0]  root
);

    localparam int W = wsm_pkg::SUM_W + 1;
    localparam logic [W-1:0] BIT_TOP = W'(1) << (W - 2);

    logic         busy_reg, busy_next;
    logic [W-1:0] x_reg, x_next;
    logic [W-1:0] res_reg, res_next;
    logic [W-1:0] bit_reg, bit_next;
    logic [W-1:0] trial;

    assign trial = res_reg + bit_reg;

    // one step of the digit-by-digit root
    always_comb
    begin
        busy_next = busy_reg;
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            x_next    = {1'b0, radicand};
            res_next  = '0;
            bit_next  = BIT_TOP;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_next   = x_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[wsm_pkg::ROOT_W-1:0];

endmodule

[sv/waveset_rms_peak_metrics_top.sv]
// ----------------------------------------------------------------------------
// waveset_rms_peak_metrics_top
// RMS level, local maximum count, length and duration of one waveset.
// ----------------------------------------------------------------------------
// Samples arrive on the s_ channel, one per transfer, tlast on the final
// sample of a waveset. One result per waveset leaves on the m_ channel after
// the marked sample.
// Each sample is accepted, squared and then accumulated; s_tready is low
// while it is squared and accumulated. The duration is kept per sample by a
// compare and subtract. The marked sample then runs the back end: a 63-step
// serial divide for the mean square, then the root unit (32 steps), before
// m_tvalid rises. The serial divider is the longer of the two back-end units.
// The result sits in an output register: while the receiver stalls, the next
// waveset is taken in; a second result waits in the sequencer until the
// register frees, with s_tready low meanwhile.
// Reset clears all waveset state and drops m_tvalid; no clearing pass.
// Samples past MAX_LEN only set the overflow flag in m_tuser.
// ----------------------------------------------------------------------------
module waveset_rms_peak_metrics_top #(
    parameter int MAX_LEN     = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // sample
    input  logic                                 s_tlast,  // last sample of waveset
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [79:0]                          m_tdata,  // rms_level, peak_total,
                                                           // length, duration
    output logic                                 m_tuser   // overflow
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MUL       = 3'd1;
    localparam logic [2:0] ST_ADD       = 3'd2;
    localparam logic [2:0] ST_MEAN      = 3'd3;
    localparam logic [2:0] ST_MEAN_WAIT = 3'd4;
    localparam logic [2:0] ST_ROOT      = 3'd5;
    localparam logic [2:0] ST_ROOT_WAIT = 3'd6;
    localparam logic [2:0] ST_OUT       = 3'd7;

    logic [2:0] state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;
    logic [wsm_pkg::SUM_W-1:0]     mean_reg, mean_next;

    logic [wsm_pkg::RMS_W-1:0]     rms_reg;
    logic [wsm_pkg::PEAK_W-1:0]    peak_out_reg;
    logic [wsm_pkg::LEN_OUT_W-1:0] len_out_reg;
    logic [wsm_pkg::DUR_W-1:0]     dur_reg;
    logic                          over_out_reg;
    logic                          out_valid_reg, out_valid_next;

    wsm_pkg::wsm_acc_ctrl_t        acc_ctrl;
    wsm_pkg::wsm_acc_stat_t        acc_stat;
    logic [CNT_W-1:0]              count;

    logic                          in_xfer;
    logic                          out_free;
    logic                          out_load;
    logic                          div_start;
    logic                          div_busy;
    logic [wsm_pkg::SUM_W-1:0]     div_num;
    logic [CNT_W-1:0]              div_den;
    logic [wsm_pkg::SUM_W-1:0]     div_quot;
    logic                          sqrt_start;
    logic                          sqrt_busy;
    logic [wsm_pkg::ROOT_W-1:0]    sqrt_root;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    // accumulator steps
    assign acc_ctrl.mul   = (state_reg == ST_MUL);
    assign acc_ctrl.add   = (state_reg == ST_ADD);
    assign acc_ctrl.clear = out_load;

    // back-end unit starts and divider operands
    assign div_start  = (state_reg == ST_MEAN);
    assign sqrt_start = (state_reg == ST_ROOT);
    assign div_num    = acc_stat.sum;
    assign div_den    = count;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mean_next  = mean_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = last_reg ? ST_MEAN : ST_IDLE;
            end
            ST_MEAN:
            begin
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (!div_busy)
                begin
                    mean_next  = (count == '0) ? '0 : div_quot;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (!sqrt_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input hold and result payload
    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        if (in_xfer)
        begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            last_reg   <= s_tlast;
        end
        if (out_load)
        begin
            rms_reg      <= sqrt_root[wsm_pkg::RMS_W-1:0];
            peak_out_reg <= acc_stat.peak;
            len_out_reg  <= wsm_pkg::LEN_OUT_W'(count);
            dur_reg      <= acc_stat.dur;
            over_out_reg <= acc_stat.over;
        end
    end

    // per-sample accumulation
    wsm_accum #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .sample (sample_reg),
        .count  (count),
        .stat   (acc_stat)
    );

    // serial divider for the mean square
    wsm_divider #(
        .NUM_W (wsm_pkg::SUM_W),
        .DEN_W (CNT_W)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // square root unit
    wsm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (mean_reg),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, dur_reg, len_out_reg, peak_out_reg, rms_reg};
    assign m_tuser  = over_out_reg;

    // divider never restarted mid-division
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // root unit never restarted mid-run
    a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_busy)
        else $error("root unit started while busy");

    // one sample at a time
    a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("sample accepted during processing");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !out_load)
        else $error("pending result overwritten");

endmodule

[verif/wsm_metrics_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsm_metrics_checker
// Watches the sample and result channels of the waveset metrics block,
// predicts each waveset's rms level, local maximum count, length, duration
// and overflow flag, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module wsm_metrics_checker #(
    parameter int MAX_LEN  = 65536,
    parameter int SAMPLE_W = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [((SAMPLE_W+7)/8)*8-1:0]     s_tdata,   // sample
    input  logic                              s_tlast,   // last sample of waveset
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [79:0]                       m_tdata,   // rms_level, peak_total,
                                                         // length, duration
    input  logic                              m_tuser,   // overflow
    output int                                fail_count,
    output int                                pending,
    output int                                results_seen
);

    // field positions in m_tdata, lowest first
    localparam int PEAK_LSB = wsm_pkg::RMS_W;
    localparam int LEN_LSB  = PEAK_LSB + wsm_pkg::PEAK_W;
    localparam int DUR_LSB  = LEN_LSB + wsm_pkg::LEN_OUT_W;

    typedef struct packed {
        logic [wsm_pkg::RMS_W-1:0]     rms;
        logic [wsm_pkg::PEAK_W-1:0]    peaks;
        logic [wsm_pkg::LEN_OUT_W-1:0] len;
        logic [wsm_pkg::DUR_W-1:0]     dur;
        logic                          ovf;
    } metrics_t;

    metrics_t metrics_due[$];

    // running waveset state
    logic [wsm_pkg::SUM_W-1:0]  energy;
    int                         taken;
    logic signed [SAMPLE_W-1:0] last1;
    logic signed [SAMPLE_W-1:0] last2;
    int                         history;
    logic [wsm_pkg::PEAK_W-1:0] peaks;
    logic                       overrun;

    task automatic clear_waveset();
        energy  = '0;
        taken   = 0;
        last1   = '0;
        last2   = '0;
        history = 0;
        peaks   = '0;
        overrun = 1'b0;
    endtask

    // bitwise integer square root, floor
    function automatic logic [31:0] int_sqrt(input logic [63:0] val);
        logic [31:0] root;
        logic [31:0] cand;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = root | (32'd1 << b);
            if (64'(cand) * 64'(cand) <= val)
                root = cand;
        end
        return root;
    endfunction

    // fold one accepted sample into the waveset, emit metrics on the marked one
    task automatic absorb_sample(input logic [SAMPLE_W-1:0] raw, input logic fin);
        logic signed [SAMPLE_W-1:0] smp;
        logic [SAMPLE_W-1:0]        mag;
        logic [wsm_pkg::SUM_W-1:0]  sq;
        logic [63:0]                mean;
        metrics_t                   res;
        smp = raw;
        if (taken >= MAX_LEN)
            overrun = 1'b1;
        else
        begin
            mag = smp[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
            sq  = wsm_pkg::SUM_W'(mag) * wsm_pkg::SUM_W'(mag);
            if (energy > wsm_pkg::SUM_LIMIT - sq)
                energy = wsm_pkg::SUM_LIMIT;
            else
                energy = energy + sq;
            taken++;
            // strict local maximum at the previous sample
            if (history >= 2 && last1 > last2 && smp < last1 && peaks != wsm_pkg::PEAK_MAX)
                peaks++;
            last2 = last1;
            last1 = smp;
            if (history < 2)
                history++;
        end
        if (fin)
        begin
            mean      = (taken != 0) ? 64'(energy) / 64'(taken) : 64'd0;
            res.rms   = wsm_pkg::RMS_W'(int_sqrt(mean));
            res.peaks = peaks;
            res.len   = wsm_pkg::LEN_OUT_W'(taken);
            res.dur   = wsm_pkg::DUR_W'((64'(taken) << wsm_pkg::DUR_SHIFT)
                                        / 64'(wsm_pkg::RATE_HZ));
            res.ovf   = overrun;
            metrics_due.push_back(res);
            clear_waveset();
        end
    endtask

    task automatic report(input string field, input logic [63:0] want_v,
                          input logic [63:0] got_v);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    // compare one result transfer with the oldest prediction
    task automatic check_result();
        metrics_t want;
        metrics_t got;
        got.rms   = m_tdata[wsm_pkg::RMS_W-1:0];
        got.peaks = m_tdata[PEAK_LSB +: wsm_pkg::PEAK_W];
        got.len   = m_tdata[LEN_LSB +: wsm_pkg::LEN_OUT_W];
        got.dur   = m_tdata[DUR_LSB +: wsm_pkg::DUR_W];
        got.ovf   = m_tuser;
        results_seen++;
        if (metrics_due.size() == 0)
        begin
            fail_count++;
            $display("%0t: result with none expected, expected nothing, got data %h overflow %b",
                     $time, m_tdata, m_tuser);
        end
        else
        begin
            want = metrics_due.pop_front();
            if (got.rms !== want.rms)
                report("rms_level", 64'(want.rms), 64'(got.rms));
            if (got.peaks !== want.peaks)
                report("peak_total", 64'(want.peaks), 64'(got.peaks));
            if (got.len !== want.len)
                report("length", 64'(want.len), 64'(got.len));
            if (got.dur !== want.dur)
                report("duration", 64'(want.dur), 64'(got.dur));
            if (got.ovf !== want.ovf)
                report("overflow", 64'(want.ovf), 64'(got.ovf));
        end
    endtask

    // transfers are taken at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_waveset();
            metrics_due.delete();
            fail_count   = 0;
            results_seen = 0;
            pending      = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                absorb_sample(s_tdata[SAMPLE_W-1:0], s_tlast);
            pending = metrics_due.size();
        end
    end

endmodule

[verif/tb_waveset_rms_peak_metrics_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_waveset_rms_peak_metrics_top
// Drives wavesets of audio samples into the metrics block: short directed
// edge cases, then random wavesets of several shapes under three idling
// phases. A checker module predicts and compares every result; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_waveset_rms_peak_metrics_top;

    localparam int MAX_LEN      = 65536;
    localparam int SAMPLE_W     = 24;
    localparam int DATA_W       = ((SAMPLE_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1030;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    localparam logic [SAMPLE_W-1:0] SMP_MAX = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] SMP_MIN = 24'h800000;

    typedef enum int {
        SHAPE_NOISE,
        SHAPE_ZIGZAG,
        SHAPE_PLATEAU,
        SHAPE_EXTREME
    } shape_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // sample
    logic              s_tlast;   // last sample of waveset
    logic              m_tvalid;
    logic              m_tready;
    logic [79:0]       m_tdata;   // rms_level, peak_total, length, duration
    logic              m_tuser;   // overflow

    int fail_count;
    int pending;
    int results_seen;
    int src_idle_pct;
    int dst_idle_pct;
    int samples_sent;
    int quiet_cycles;

    waveset_rms_peak_metrics_top #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    wsm_metrics_checker #(
        .MAX_LEN  (MAX_LEN),
        .SAMPLE_W (SAMPLE_W)
    ) metrics_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls at random, per phase
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                             $time, quiet_cycles, pending);
                    $display("tb_waveset_rms_peak_metrics_top: FAIL");
                    $finish;
                end
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample(input shape_t shape, input int idx);
        logic [SAMPLE_W-1:0] val;
        case (shape)
            SHAPE_ZIGZAG:
                if (idx % 2 == 0)
                    val = SAMPLE_W'($urandom_range(0, 8388607));
                else
                    val = SAMPLE_W'(-int'($urandom_range(1, 8388608)));
            // tiny values so neighbors are often equal
            SHAPE_PLATEAU:
                val = SAMPLE_W'(int'($urandom_range(0, 3)) - 1);
            SHAPE_EXTREME:
                case ($urandom_range(0, 3))
                    0:       val = SMP_MIN;
                    1:       val = SMP_MAX;
                    2:       val = '0;
                    default: val = '1;
                endcase
            default:
                val = SAMPLE_W'($urandom());
        endcase
        return val;
    endfunction

    // one sample transfer, entered and left at a falling edge
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic fin);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = DATA_W'(smp);
        s_tlast  = fin;
        do
            @(posedge clk);
        while (!s_tready);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic send_waveset(input int len, input shape_t shape);
        for (int i = 0; i < len; i++)
            push_sample(pick_sample(shape, i), i == len - 1);
    endtask

    initial
    begin
        int     sent_random;
        int     len;
        shape_t shape;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        samples_sent = 0;
        quiet_cycles = 0;
        sent_random  = 0;
        rst_n        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // sender mostly busy, receiver mostly stalled
        src_idle_pct = 25;
        dst_idle_pct = 85;

        // lone samples at both full-scale ends
        push_sample(SMP_MAX, 1'b1);
        push_sample(SMP_MIN, 1'b1);
        // two samples can never complete a peak
        push_sample('0, 1'b0);
        push_sample(SAMPLE_W'(-1), 1'b1);
        // plain strict maximum
        push_sample(SAMPLE_W'(1), 1'b0);
        push_sample(SAMPLE_W'(5), 1'b0);
        push_sample(SAMPLE_W'(2), 1'b1);
        // flat top is not a peak
        push_sample(SAMPLE_W'(1), 1'b0);
        push_sample(SAMPLE_W'(5), 1'b0);
        push_sample(SAMPLE_W'(5), 1'b0);
        push_sample(SAMPLE_W'(2), 1'b1);
        // full-swing peak
        push_sample(SMP_MIN, 1'b0);
        push_sample(SMP_MAX, 1'b0);
        push_sample(SMP_MIN, 1'b1);
        // largest rms
        push_sample(SMP_MIN, 1'b0);
        push_sample(SMP_MIN, 1'b0);
        push_sample(SMP_MIN, 1'b1);
        // peak among negative values
        push_sample(SAMPLE_W'(-3), 1'b0);
        push_sample(SAMPLE_W'(-1), 1'b0);
        push_sample(SAMPLE_W'(-2), 1'b1);

        // random wavesets, mostly short
        while (sent_random < RANDOM_ITEMS)
        begin
            if (sent_random >= 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            else if (sent_random >= RANDOM_ITEMS / 3)
            begin
                src_idle_pct = 85;
                dst_idle_pct = 25;
            end
            len = ($urandom_range(99) < 5) ? $urandom_range(25, 120) : $urandom_range(1, 24);
            shape = shape_t'($urandom_range(SHAPE_NOISE, SHAPE_EXTREME));
            send_waveset(len, shape);
            sent_random += len;
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        // drain outstanding results, then let the back end settle
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d samples and %0d waveset results", samples_sent, results_seen);
        $display("incl. full-scale, flat-top and negative-peak wavesets, 3 idle phases");
        if (fail_count == 0)
            $display("tb_waveset_rms_peak_metrics_top: PASS");
        else
            $display("tb_waveset_rms_peak_metrics_top: FAIL");
        $finish;
    end

endmodule

[waveset_rms_peak_metrics_top.f]
sv/wsm_pkg.sv
sv/wsm_accum.sv
sv/wsm_divider.sv
sv/wsm_isqrt.sv
sv/waveset_rms_peak_metrics_top.sv
verif/wsm_metrics_checker.sv
verif/tb_waveset_rms_peak_metrics_top.sv
